// ----- src/sine_tone_generator_assert.svh -----
// Assertion macros for the tone generator port checker.
// Needs nothing else; included by the files that assert.
`ifndef SINE_TONE_GENERATOR_ASSERT_SVH
`define SINE_TONE_GENERATOR_ASSERT_SVH

// Same-cycle implication, disabled while rst is high.
`define STG_ASSERT_NOW(label, clk, rst, ante, cons, msg) \
   label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
      else $error(msg);

// Next-cycle implication, disabled while rst is high.
`define STG_ASSERT_NEXT(label, clk, rst, ante, cons, msg) \
   label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
      else $error(msg);

`endif

// ----- src/stg_pkg.sv -----
// Package for the sine tone generator: widths, codes, defaults and the
// elaboration-time sine table functions. Depends on nothing.
`default_nettype none

package stg_pkg;

   // Parameter defaults
   localparam int SAMPLE_RATE_HZ_DEFAULT   = 16000;
   localparam int PHASE_BITS_DEFAULT       = 32;
   localparam int SINE_TABLE_DEPTH_DEFAULT = 256;

   // Field widths
   localparam int FREQ_W   = 13;
   localparam int DUR_W    = 16;
   localparam int SAMPLE_W = 15;
   localparam int COUNT_W  = 21;
   localparam int VOL_W    = 7;
   localparam int ENTRY_W  = 16;   // table entry, 0..32768
   localparam int SCALE_W  = 14;   // volume * 160, 0..16000
   localparam int ENTRY_FRAC = 15; // entries are Q15

   localparam logic [FREQ_W-1:0]  FREQ_MAX     = 13'd7999;
   localparam logic [VOL_W-1:0]   VOLUME_MAX   = 7'd100;
   localparam logic [VOL_W-1:0]   VOLUME_RESET = 7'd100;
   localparam logic [COUNT_W-1:0] COUNT_MAX    = {COUNT_W{1'b1}};

   localparam int FULL_SCALE    = 16000;
   localparam int PERCENT       = 100;
   localparam int SCALE_PER_PCT = FULL_SCALE / PERCENT;
   localparam logic [SCALE_W-1:0] SCALE_RESET = SCALE_W'(FULL_SCALE);
   localparam int MS_PER_S      = 1000;

   // Fraction bits of the reciprocal constants (exact floor for all inputs)
   localparam int STEP_FRAC_BITS  = 29;
   localparam int COUNT_FRAC_BITS = 26;

   localparam logic [63:0] HALF_PI_Q30 = 64'd1686629713;

   // CSR map
   localparam int CSR_ADDR_W = 3;
   localparam int CSR_DATA_W = 32;
   localparam int REG_IDX_W  = 1;
   localparam logic [REG_IDX_W-1:0] REG_VOLUME = 1'b0;

   typedef enum logic {
      OP_START = 1'b0,
      OP_TICK  = 1'b1
   } stg_op_type;

   // log2 of the table depth, rounded down, at least 2
   function automatic int table_bits(input int depth);
      int db;
      db = 2;
      for (int b = 3; b <= 16; b++) begin
         if ((1 << b) <= depth) begin
            db = b;
         end
      end
      return db;
   endfunction

   // Taylor series sine, Q30 in and out, 0 <= x <= pi/2
   function automatic logic [63:0] sine_q30(input logic [63:0] x);
      logic [63:0] x2;
      logic [63:0] term;
      longint      sum;
      x2   = (x * x) >> 30;
      term = ((x * x2) >> 30) / 64'd6;
      sum  = longint'(x) - longint'(term);
      term = ((term * x2) >> 30) / 64'd20;
      sum  = sum + longint'(term);
      term = ((term * x2) >> 30) / 64'd42;
      sum  = sum - longint'(term);
      term = ((term * x2) >> 30) / 64'd72;
      sum  = sum + longint'(term);
      term = ((term * x2) >> 30) / 64'd110;
      sum  = sum - longint'(term);
      term = ((term * x2) >> 30) / 64'd156;
      sum  = sum + longint'(term);
      term = ((term * x2) >> 30) / 64'd210;
      sum  = sum - longint'(term);
      if (sum < 0) begin
         sum = 0;
      end
      if (sum > (longint'(1) << 30)) begin
         sum = longint'(1) << 30;
      end
      return 64'(sum);
   endfunction

   // Quarter-wave entry i of 2^qbits steps, rounded Q15
   function automatic logic [ENTRY_W-1:0] quarter_entry(input int i, input int qbits);
      logic [63:0] x;
      x = (64'(i) * HALF_PI_Q30 + ((64'd1 << qbits) >> 1)) >> qbits;
      return ENTRY_W'((sine_q30(x) + 64'd16384) >> ENTRY_FRAC);
   endfunction

endpackage

`default_nettype wire

// ----- src/stg_start_calc.sv -----
// Start-item math: phase step and sample count from frequency and duration.
// Uses stg_pkg. Reciprocal multiplies replace the constant divides.
`default_nettype none

module stg_start_calc
   import stg_pkg::*;
#(
   parameter int SAMPLE_RATE_HZ = SAMPLE_RATE_HZ_DEFAULT,
   parameter int PHASE_BITS     = PHASE_BITS_DEFAULT
) (
   input  wire logic [FREQ_W-1:0]     freq_hz,
   input  wire logic [DUR_W-1:0]      duration_ms,
   output logic      [PHASE_BITS-1:0] phase_step,
   output logic      [COUNT_W-1:0]    sample_count
);

   // step = f*U + floor(f*C / 2^29), U = 2^P div SR, C = ceil(rem * 2^29 / SR)
   localparam logic [63:0] STEP_INT  = (64'd1 << PHASE_BITS) / SAMPLE_RATE_HZ;
   localparam logic [63:0] STEP_REM  = (64'd1 << PHASE_BITS) % SAMPLE_RATE_HZ;
   localparam logic [63:0] STEP_FRAC =
      (STEP_REM * (64'd1 << STEP_FRAC_BITS) + 64'(SAMPLE_RATE_HZ) - 64'd1) / SAMPLE_RATE_HZ;
   localparam int STEP_INT_W = $clog2(STEP_INT + 64'd1);
   localparam logic [STEP_INT_W-1:0]     STEP_INT_C  = STEP_INT_W'(STEP_INT);
   localparam logic [STEP_FRAC_BITS-1:0] STEP_FRAC_C = STEP_FRAC_BITS'(STEP_FRAC);

   // count = floor(d * ceil(SR * 2^26 / 1000) / 2^26)
   localparam logic [63:0] COUNT_MUL =
      (64'(SAMPLE_RATE_HZ) * (64'd1 << COUNT_FRAC_BITS) + 64'(MS_PER_S) - 64'd1) / MS_PER_S;
   localparam int COUNT_MUL_W = 32;
   localparam logic [COUNT_MUL_W-1:0] COUNT_MUL_C = COUNT_MUL_W'(COUNT_MUL);

   logic [FREQ_W-1:0]                freq_sat;
   logic [FREQ_W+STEP_INT_W-1:0]     int_prod;
   logic [FREQ_W+STEP_FRAC_BITS-1:0] frac_prod;
   logic [PHASE_BITS:0]              step_sum;
   logic [DUR_W+COUNT_MUL_W-1:0]     count_prod;
   logic [COUNT_W:0]                 count_raw;

   always_comb begin
      freq_sat  = (freq_hz > FREQ_MAX) ? FREQ_MAX : freq_hz;
      int_prod  = freq_sat * STEP_INT_C;
      frac_prod = freq_sat * STEP_FRAC_C;
      step_sum  = (PHASE_BITS+1)'(int_prod)
                + (PHASE_BITS+1)'(frac_prod[FREQ_W+STEP_FRAC_BITS-1:STEP_FRAC_BITS]);
      phase_step = step_sum[PHASE_BITS-1:0];

      count_prod = duration_ms * COUNT_MUL_C;
      count_raw  = (COUNT_W+1)'(count_prod >> COUNT_FRAC_BITS);
      sample_count = (count_raw > {1'b0, COUNT_MAX}) ? COUNT_MAX : count_raw[COUNT_W-1:0];
   end

endmodule

`default_nettype wire

// ----- src/stg_sine_lookup.sv -----
// Quarter-wave sine lookup and volume scaling for one phase value.
// Uses stg_pkg for the table functions and widths.
`default_nettype none

module stg_sine_lookup
   import stg_pkg::*;
#(
   parameter int PHASE_BITS       = PHASE_BITS_DEFAULT,
   parameter int SINE_TABLE_DEPTH = SINE_TABLE_DEPTH_DEFAULT
) (
   input  wire logic        [PHASE_BITS-1:0] phase,
   input  wire logic        [SCALE_W-1:0]    scale,
   output logic signed      [SAMPLE_W-1:0]   sample
);

   localparam int DB     = table_bits(SINE_TABLE_DEPTH);
   localparam int QB     = DB - 2;
   localparam int QDEPTH = 1 << QB;

   logic [ENTRY_W-1:0] quarter_rom [QDEPTH+1];

   for (genvar i = 0; i <= QDEPTH; i++) begin : g_rom
      assign quarter_rom[i] = quarter_entry(i, QB);
   end

   logic [DB-1:0]              idx;
   logic [1:0]                 quad;
   logic [QB-1:0]              pos;
   logic [QB:0]                addr;
   logic [ENTRY_W-1:0]         entry;
   logic [ENTRY_W+SCALE_W-1:0] prod;
   logic [SAMPLE_W-1:0]        mag;

   always_comb begin
      idx   = phase[PHASE_BITS-1 -: DB];
      quad  = idx[DB-1:DB-2];
      pos   = idx[QB-1:0];
      // odd quadrants run the table backwards
      addr  = quad[0] ? ((QB+1)'(QDEPTH) - {1'b0, pos}) : {1'b0, pos};
      entry = quarter_rom[addr];
      prod  = entry * scale;
      mag   = SAMPLE_W'(prod >> ENTRY_FRAC);
      // sign after truncation: rounds toward zero
      sample = quad[1] ? -$signed(mag) : $signed(mag);
   end

endmodule

`default_nettype wire

// ----- src/sine_tone_generator.sv -----
// Sine tone generator top level: handshakes, tone state, volume CSR.
// Uses stg_pkg, stg_start_calc and stg_sine_lookup.
//
//   channel | direction | handshake           | payload
//   --------+-----------+---------------------+---------------------------------------
//   req     | in        | req_valid/req_stall | operation, tone_freq_hz, tone_duration_ms
//   rsp     | out       | rsp_valid/rsp_stall | left_sample, right_sample, last_of_tone
//   csr     | in/out    | APB psel/penable    | volume_percent at byte 0
//
// One item per clock unless a stalled result holds back a tick. An item is
// registered in the input register, and a tick's sample then in the result
// register. The combinational path is the start math multiply or the table
// read plus the volume multiply. Reset is synchronous; no clearing pass is needed.
// A stalled result holds; the input register still drains start items and
// idle ticks, and only stalls when a tick needs the occupied result slot.
`default_nettype none

module sine_tone_generator
   import stg_pkg::*;
#(
   parameter int SAMPLE_RATE_HZ   = SAMPLE_RATE_HZ_DEFAULT,
   parameter int PHASE_BITS       = PHASE_BITS_DEFAULT,
   parameter int SINE_TABLE_DEPTH = SINE_TABLE_DEPTH_DEFAULT
) (
   input  wire logic                       clock,
   input  wire logic                       reset,
   // input item transfer
   input  wire logic                       req_valid,
   output logic                            req_stall,
   input  wire logic                       req_operation,
   input  wire logic [FREQ_W-1:0]          req_tone_freq_hz,
   input  wire logic [DUR_W-1:0]           req_tone_duration_ms,
   // result transfer
   output logic                            rsp_valid,
   input  wire logic                       rsp_stall,
   output logic signed [SAMPLE_W-1:0]      rsp_left_sample,
   output logic signed [SAMPLE_W-1:0]      rsp_right_sample,
   output logic                            rsp_last_of_tone,
   // configuration
   input  wire logic                       csr_psel,
   input  wire logic                       csr_penable,
   input  wire logic                       csr_pwrite,
   input  wire logic [CSR_ADDR_W-1:0]      csr_paddr,
   input  wire logic [CSR_DATA_W-1:0]      csr_pwdata,
   output logic      [CSR_DATA_W-1:0]      csr_prdata,
   output logic                            csr_pready
);

   // ---------------- input register ----------------
   logic                  in_valid_ff, in_valid_in;
   stg_op_type            in_op_ff, in_op_in;
   logic [FREQ_W-1:0]     in_freq_ff, in_freq_in;
   logic [DUR_W-1:0]      in_dur_ff, in_dur_in;

   // ---------------- tone state ----------------
   logic [PHASE_BITS-1:0] phase_ff, phase_in;
   logic [PHASE_BITS-1:0] step_ff, step_in;
   logic [COUNT_W-1:0]    count_ff, count_in;

   // ---------------- volume ----------------
   logic [VOL_W-1:0]      vol_ff, vol_in;
   logic [SCALE_W-1:0]    scale_ff, scale_in;

   // ---------------- result register ----------------
   logic                       rsp_valid_ff, rsp_valid_in;
   logic signed [SAMPLE_W-1:0] rsp_sample_ff, rsp_sample_in;
   logic                       rsp_last_ff, rsp_last_in;

   // ---------------- datapath ----------------
   logic [PHASE_BITS-1:0]      calc_step;
   logic [COUNT_W-1:0]         calc_count;
   logic signed [SAMPLE_W-1:0] lookup_sample;

   stg_start_calc #(
      .SAMPLE_RATE_HZ (SAMPLE_RATE_HZ),
      .PHASE_BITS     (PHASE_BITS)
   ) u_start_calc (
      .freq_hz      (in_freq_ff),
      .duration_ms  (in_dur_ff),
      .phase_step   (calc_step),
      .sample_count (calc_count)
   );

   stg_sine_lookup #(
      .PHASE_BITS       (PHASE_BITS),
      .SINE_TABLE_DEPTH (SINE_TABLE_DEPTH)
   ) u_sine_lookup (
      .phase  (phase_ff),
      .scale  (scale_ff),
      .sample (lookup_sample)
   );

   // ---------------- flow control ----------------
   logic emits;     // held item is a tick with samples left
   logic out_free;  // result slot empty or draining this cycle
   logic advance;   // held item is processed this cycle
   logic csr_write;
   logic [REG_IDX_W-1:0] csr_index;
   logic [VOL_W-1:0]     vol_wr;

   always_comb begin
      emits     = (in_op_ff == OP_TICK) && (count_ff != '0);
      out_free  = !rsp_valid_ff || !rsp_stall;
      advance   = in_valid_ff && (!emits || out_free);
      req_stall = in_valid_ff && !advance;
   end

   // input register: refills whenever the held item moves on
   always_comb begin
      in_valid_in = in_valid_ff;
      in_op_in    = in_op_ff;
      in_freq_in  = in_freq_ff;
      in_dur_in   = in_dur_ff;
      if (!req_stall) begin
         in_valid_in = req_valid;
         if (req_valid) begin
            in_op_in   = stg_op_type'(req_operation);
            in_freq_in = req_tone_freq_hz;
            in_dur_in  = req_tone_duration_ms;
         end
      end
   end

   // tone state update
   always_comb begin
      phase_in = phase_ff;
      step_in  = step_ff;
      count_in = count_ff;
      if (advance) begin
         unique case (in_op_ff)
            OP_START: begin
               // restart: phase from zero, new step and length
               phase_in = '0;
               step_in  = calc_step;
               count_in = calc_count;
            end
            OP_TICK: begin
               if (emits) begin
                  phase_in = phase_ff + step_ff;  // wraps at 2^PHASE_BITS
                  count_in = count_ff - COUNT_W'(1);
               end
            end
            default: begin
               phase_in = phase_ff;
            end
         endcase
      end
   end

   // result register
   always_comb begin
      rsp_valid_in  = rsp_valid_ff;
      rsp_sample_in = rsp_sample_ff;
      rsp_last_in   = rsp_last_ff;
      if (out_free) begin
         rsp_valid_in  = advance && emits;
         rsp_sample_in = lookup_sample;
         rsp_last_in   = (count_ff == COUNT_W'(1));
      end
   end

   // ---------------- CSR ----------------
   always_comb begin
      csr_pready = 1'b1;
      csr_write  = csr_psel && csr_penable && csr_pwrite;
      csr_index  = csr_paddr[CSR_ADDR_W-1 -: REG_IDX_W];
      // only the low 7 bits are taken; values above full volume clamp to full volume
      vol_wr     = (csr_pwdata[VOL_W-1:0] > VOLUME_MAX) ? VOLUME_MAX : csr_pwdata[VOL_W-1:0];
      vol_in     = vol_ff;
      scale_in   = scale_ff;
      if (csr_write && (csr_index == REG_VOLUME)) begin
         vol_in   = vol_wr;
         scale_in = SCALE_W'(vol_wr * SCALE_PER_PCT);
      end
      csr_prdata = '0;
      if (csr_index == REG_VOLUME) begin
         csr_prdata = CSR_DATA_W'(vol_ff);
      end
   end

   // control and state registers
   always_ff @(posedge clock) begin
      if (reset) begin
         in_valid_ff  <= 1'b0;
         rsp_valid_ff <= 1'b0;
         phase_ff     <= '0;
         step_ff      <= '0;
         count_ff     <= '0;
         vol_ff       <= VOLUME_RESET;
         scale_ff     <= SCALE_RESET;
      end else begin
         in_valid_ff  <= in_valid_in;
         rsp_valid_ff <= rsp_valid_in;
         phase_ff     <= phase_in;
         step_ff      <= step_in;
         count_ff     <= count_in;
         vol_ff       <= vol_in;
         scale_ff     <= scale_in;
      end
   end

   // payload registers
   always_ff @(posedge clock) begin
      in_op_ff      <= in_op_in;
      in_freq_ff    <= in_freq_in;
      in_dur_ff     <= in_dur_in;
      rsp_sample_ff <= rsp_sample_in;
      rsp_last_ff   <= rsp_last_in;
   end

   // both channels carry the same mono sample
   assign rsp_valid        = rsp_valid_ff;
   assign rsp_left_sample  = rsp_sample_ff;
   assign rsp_right_sample = rsp_sample_ff;
   assign rsp_last_of_tone = rsp_last_ff;

endmodule

`default_nettype wire

// ----- src/stg_port_checker.sv -----
// Port-level checks for the sine tone generator, bound to the top level.
// Uses stg_pkg and the macros in sine_tone_generator_assert.svh.
`default_nettype none
`include "sine_tone_generator_assert.svh"

module stg_port_checker
   import stg_pkg::*;
(
   input wire logic                       clock,
   input wire logic                       reset,
   input wire logic                       rsp_valid,
   input wire logic                       rsp_stall,
   input wire logic signed [SAMPLE_W-1:0] rsp_left_sample,
   input wire logic signed [SAMPLE_W-1:0] rsp_right_sample,
   input wire logic                       rsp_last_of_tone
);

   localparam logic signed [SAMPLE_W-1:0] PEAK = SAMPLE_W'(FULL_SCALE);

   `STG_ASSERT_NOW(a_stereo_equal, clock, reset, rsp_valid,
      rsp_left_sample == rsp_right_sample, "left and right samples differ")

   `STG_ASSERT_NOW(a_sample_range, clock, reset, rsp_valid,
      (rsp_left_sample <= PEAK) && (rsp_left_sample >= -PEAK), "sample beyond full scale")

   `STG_ASSERT_NEXT(a_reset_clears, clock, 1'b0, reset,
      !rsp_valid, "result valid right after reset")

   `STG_ASSERT_NEXT(a_result_holds, clock, reset, rsp_valid && rsp_stall,
      rsp_valid && $stable(rsp_left_sample) && $stable(rsp_last_of_tone),
      "stalled result changed")

endmodule

bind sine_tone_generator stg_port_checker u_port_checker (.*);

`default_nettype wire
